// ===== rtl/core/bhgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bhgc_pkg: shared types and constants
// Status codes, controller states and the command/status bundles that join
// the controller and the datapath of the bucketed group-count table.
// ----------------------------------------------------------------------------
package bhgc_pkg;

  localparam int unsigned BUCKETS_DEF    = 512;
  localparam int unsigned SLOTS_DEF      = 8;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned CFG_W          = 10;
  localparam int unsigned START_W        = 9;
  localparam int unsigned WIDE_W         = 17;
  localparam logic [CFG_W-1:0] CFG_RESET = 10'd512;
  localparam logic [KEY_W-1:0] EMPTY_KEY = '0;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CNT_W-1:0] CNT_ONE   = 32'd1;

  typedef enum logic [0:0] {
    CMD_COUNT  = 1'b0,
    CMD_LOOKUP = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    ST_INCR  = 3'd0,
    ST_NEW   = 3'd1,
    ST_FOUND = 3'd2,
    ST_MISS  = 3'd3,
    ST_FULL  = 3'd4,
    ST_BAD   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic cmp;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic bad;
    logic hit;
    logic last;
  } dp_sts_t;

endpackage

// ===== rtl/core/bhgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhgc_ctrl: probe sequencer
// Runs the reset clearing pass, accepts commands and steps the datapath
// through one read and one compare per probed bucket.
// ----------------------------------------------------------------------------
module bhgc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bhgc_pkg::dp_sts_t  sts,
  output bhgc_pkg::ctl_cmd_t cmd,
  output logic               busy
);
  import bhgc_pkg::*;

  state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start && !sts.bad) state_nxt = S_CMP;
      S_READ:  state_nxt = S_CMP;
      S_CMP: begin
        if (sts.hit || sts.last) state_nxt = S_IDLE;
        else state_nxt = S_READ;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_READ:  cmd.rd  = 1'b1;
      S_CMP:   cmd.cmp = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/bhgc_dp.sv =====
// ----------------------------------------------------------------------------
// bhgc_dp: table datapath
// Bucket row memories, item registers, slot compare, count update and the
// registered result beat.
// ----------------------------------------------------------------------------
module bhgc_dp #(
  parameter int unsigned BUCKETS          = bhgc_pkg::BUCKETS_DEF,
  parameter int unsigned SLOTS_PER_BUCKET = bhgc_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bhgc_pkg::ctl_cmd_t                  cmd,
  output bhgc_pkg::dp_sts_t                   sts,
  input  logic                                cfg_wr_en,
  input  logic [bhgc_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                                in_command,
  input  logic [bhgc_pkg::KEY_W-1:0]          in_key,
  input  logic [bhgc_pkg::START_W-1:0]        in_start_bucket,
  output logic                                out_valid,
  output logic [bhgc_pkg::CNT_W-1:0]          out_count,
  output logic [2:0]                          out_status
);
  import bhgc_pkg::*;

  localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned ROW_K = SLOTS_PER_BUCKET * KEY_W;
  localparam int unsigned ROW_C = SLOTS_PER_BUCKET * CNT_W;
  localparam logic [WIDE_W-1:0] NB = WIDE_W'(BUCKETS);
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

  logic [ROW_K-1:0] key_mem [BUCKETS];
  logic [ROW_C-1:0] cnt_mem [BUCKETS];
  logic [ROW_K-1:0] krow_r;
  logic [ROW_C-1:0] crow_r;

  logic [CFG_W-1:0]  cfg_r;
  logic [BW-1:0]     clr_r;
  logic [BW-1:0]     bucket_r, bucket_nxt;
  logic [CFG_W-1:0]  pc_r;
  logic [KEY_W-1:0]  key_r;
  logic              lookup_r;
  logic              ov_r;
  logic [CNT_W-1:0]  ocnt_r;
  status_t           ost_r;

  logic [WIDE_W-1:0] n_w, b1;
  logic [BW-1:0]     rd_addr;
  logic [SLOTS_PER_BUCKET-1:0] msel, fsel;
  logic              mfound, ffound;
  logic [CNT_W-1:0]  mcnt, inc_cnt;
  logic [ROW_K-1:0]  krow_w;
  logic [ROW_C-1:0]  crow_w;
  logic              wr_en;

  // buckets in use, capped at table size
  assign n_w = ({7'd0, cfg_r} > NB) ? NB : {7'd0, cfg_r};

  // reject key zero and start past the buckets in use
  assign sts.bad      = (in_key == EMPTY_KEY) ||
                        ({8'd0, in_start_bucket} >= n_w);
  assign sts.last     = ({7'd0, pc_r} + WIDE_W'(1)) == n_w;
  assign sts.hit      = mfound || ffound;
  assign sts.clr_last = (clr_r == LAST_ROW);

  // next bucket with wrap
  assign b1         = WIDE_W'(bucket_r) + WIDE_W'(1);
  assign bucket_nxt = (b1 == n_w) ? '0 : b1[BW-1:0];

  always_comb begin
    logic [WIDE_W-1:0] sb;
    sb = {8'd0, in_start_bucket};
    rd_addr = cmd.load ? sb[BW-1:0] : bucket_r;
  end

  // pick lowest matching and lowest empty slot
  always_comb begin
    msel   = '0;
    fsel   = '0;
    mfound = 1'b0;
    ffound = 1'b0;
    mcnt   = '0;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (!mfound && krow_r[s*KEY_W +: KEY_W] == key_r) begin
        mfound  = 1'b1;
        msel[s] = 1'b1;
        mcnt    = crow_r[s*CNT_W +: CNT_W];
      end
      if (!ffound && krow_r[s*KEY_W +: KEY_W] == EMPTY_KEY) begin
        ffound  = 1'b1;
        fsel[s] = 1'b1;
      end
    end
  end

  assign inc_cnt = (mcnt == CNT_MAX) ? mcnt : mcnt + CNT_ONE;

  // build write-back rows
  always_comb begin
    krow_w = krow_r;
    crow_w = crow_r;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (mfound) begin
        if (msel[s]) crow_w[s*CNT_W +: CNT_W] = inc_cnt;
      end else if (fsel[s]) begin
        krow_w[s*KEY_W +: KEY_W] = key_r;
        crow_w[s*CNT_W +: CNT_W] = CNT_ONE;
      end
    end
    if (cmd.clr) krow_w = '0;
  end

  assign wr_en = cmd.clr || (cmd.cmp && sts.hit && !lookup_r);

  // row memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[cmd.clr ? clr_r : bucket_r] <= krow_w;
    end
    if (wr_en && !cmd.clr) begin
      cnt_mem[bucket_r] <= crow_w;
    end
    if (cmd.load || cmd.rd) begin
      krow_r <= key_mem[rd_addr];
      crow_r <= cnt_mem[rd_addr];
    end
  end

  // config register and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
      clr_r <= '0;
    end else begin
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      if (cmd.clr)   clr_r <= clr_r + BW'(1);
    end
  end

  // item registers and probe position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_key;
      lookup_r <= in_command;
      bucket_r <= rd_addr;
      pc_r     <= '0;
    end else if (cmd.cmp && !sts.hit) begin
      bucket_r <= bucket_nxt;
      pc_r     <= pc_r + CFG_W'(1);
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= (cmd.load && sts.bad) || (cmd.cmp && (sts.hit || sts.last));
    end
    if (cmd.load) begin
      ocnt_r <= '0;
      ost_r  <= ST_BAD;
    end else if (cmd.cmp) begin
      priority if (mfound) begin
        ocnt_r <= lookup_r ? mcnt : inc_cnt;
        ost_r  <= lookup_r ? ST_FOUND : ST_INCR;
      end else if (ffound) begin
        ocnt_r <= lookup_r ? '0 : CNT_ONE;
        ost_r  <= lookup_r ? ST_MISS : ST_NEW;
      end else begin
        ocnt_r <= '0;
        ost_r  <= lookup_r ? ST_MISS : ST_FULL;
      end
    end
  end

  assign out_valid  = ov_r;
  assign out_count  = ocnt_r;
  assign out_status = ost_r;

endmodule

// ===== rtl/core/bucketed_hash_group_count_top.sv =====
// ----------------------------------------------------------------------------
// bucketed_hash_group_count_top: bucketed group-count hash table
// Linear probing over buckets of key/count slots, one bucket row per probe.
// ----------------------------------------------------------------------------
// A bad key or start bucket is answered from the load; otherwise each probed
// bucket gets a registered read of its row followed by the compare/write.
// A new item is taken only when idle, after the previous item has finished.
// Reset: synchronous, active low; a clearing pass over all BUCKETS rows empties
// the key memory while busy stays high. Results are strobes, never stalled.
module bucketed_hash_group_count_top #(
  parameter int unsigned BUCKETS          = bhgc_pkg::BUCKETS_DEF,
  parameter int unsigned SLOTS_PER_BUCKET = bhgc_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [bhgc_pkg::KEY_W-1:0]   in_key,
  input  logic [bhgc_pkg::START_W-1:0] in_start_bucket,
  output logic                         out_valid,
  output logic [bhgc_pkg::CNT_W-1:0]   out_count,
  output logic [2:0]                   out_status,
  input  logic                         cfg_wr_en,
  input  logic [bhgc_pkg::CFG_W-1:0]   cfg_wr_data
);
  import bhgc_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bhgc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bhgc_dp #(
    .BUCKETS          (BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_start_bucket (in_start_bucket),
    .out_valid       (out_valid),
    .out_count       (out_count),
    .out_status      (out_status)
  );

endmodule
